// ===== hdl/cfgov_pkg.sv =====
// Package for the conservative frequency governor.
// Holds widths, codes, reset values, controller states and the command/status structs.
// No dependencies; every other file uses it.
`timescale 1ns / 1ps

package cfgov_pkg;

  // Field and register widths
  localparam int CMD_W      = 2;
  localparam int TIME_W     = 32;
  localparam int TOT_W      = 34;
  localparam int LVL_W      = 3;
  localparam int LOAD_W     = 7;
  localparam int POLL_W     = 20;
  localparam int MODE_W     = 2;
  localparam int THR_W      = 35;
  localparam int FIELD_W    = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 35;
  // 100 * busy total needs 7 more bits than the total
  localparam int NUM_W      = TOT_W + 7;
  localparam int DIV_CNT_W  = 3;

  // Event codes
  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_WAKE   = 2'd1,
    CMD_SLEEP  = 2'd2,
    CMD_APPLY  = 2'd3
  } cmd_code_t;

  // Policy modes (code 3 behaves as performance)
  localparam logic [MODE_W-1:0] MODE_CONS = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SAVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PERF = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POLL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DOWN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FAST = 3'd5;

  // Register reset values
  localparam logic [POLL_W-1:0] RST_POLL = 20'd100000;
  localparam logic [MODE_W-1:0] RST_MODE = MODE_PERF;
  localparam logic [THR_W-1:0]  RST_UP   = 35'd84879458;
  localparam logic [THR_W-1:0]  RST_DOWN = 35'd497990;
  localparam logic [LVL_W-1:0]  RST_SLOW = 3'd4;
  localparam logic [LVL_W-1:0]  RST_FAST = 3'd0;

  // Limits
  localparam logic [POLL_W-1:0]  MIN_POLL    = 20'd10000;
  localparam logic [POLL_W-1:0]  MAX_POLL    = 20'd1000000;
  localparam logic [FIELD_W-1:0] MAX_UP_LOAD = 7'd98;
  localparam logic [LOAD_W-1:0]  FULL_LOAD   = 7'd100;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_CHK,
    S_MUL,
    S_DIV,
    S_DEC,
    S_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic                 load_in;
    logic                 do_exec;
    logic                 do_chk;
    logic                 do_mul;
    logic                 div_step;
    logic [DIV_CNT_W-1:0] div_shift;
    logic                 do_dec;
    logic                 load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic sample_go;
    logic over_poll;
  } sts_t;

  // Per-level threshold field; levels past the fifth read zero
  function automatic logic [FIELD_W-1:0] field7(input logic [THR_W-1:0] packed_thr,
                                                input logic [LVL_W-1:0] lvl);
    logic [FIELD_W-1:0] f;
    unique case (lvl)
      3'd0:    f = packed_thr[6:0];
      3'd1:    f = packed_thr[13:7];
      3'd2:    f = packed_thr[20:14];
      3'd3:    f = packed_thr[27:21];
      3'd4:    f = packed_thr[34:28];
      default: f = '0;
    endcase
    return f;
  endfunction

endpackage

// ===== hdl/cfgov_ifs.sv =====
// Handshake channels of the governor: event input, result output, register writes.
// Depends on cfgov_pkg for payload widths.
`timescale 1ns / 1ps

interface cfgov_in_if;
  logic                        valid;
  logic                        ready;
  logic [cfgov_pkg::CMD_W-1:0]  command;
  logic [cfgov_pkg::TIME_W-1:0] wall_time_us;
  logic [cfgov_pkg::TIME_W-1:0] busy_time_us;
  logic                        was_napping;

  modport source (output valid, command, wall_time_us, busy_time_us, was_napping,
                  input ready);
  modport sink   (input valid, command, wall_time_us, busy_time_us, was_napping,
                  output ready);
endinterface

interface cfgov_out_if;
  logic                        valid;
  logic                        ready;
  logic [cfgov_pkg::LVL_W-1:0]  power_level;
  logic                        level_changed;
  logic                        decision_taken;
  logic [cfgov_pkg::LOAD_W-1:0] load_percent;

  modport source (output valid, power_level, level_changed, decision_taken, load_percent,
                  input ready);
  modport sink   (input valid, power_level, level_changed, decision_taken, load_percent,
                  output ready);
endinterface

interface cfgov_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [cfgov_pkg::CFG_IDX_W-1:0]  index;
  logic [cfgov_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/cfgov_ctrl.sv =====
// Governor controller: sequences one request through the exec, check, multiply,
// divide and decide steps that it needs, and owns the output valid flag. Depends on cfgov_pkg.
`timescale 1ns / 1ps

module cfgov_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  cfgov_pkg::sts_t dp_sts,
  output cfgov_pkg::cmd_t ctl_cmd
);
  import cfgov_pkg::*;

  localparam logic [DIV_CNT_W-1:0] DivTop = DIV_CNT_W'(LOAD_W - 1);

  state_t               state_r, state_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_EXEC;
      S_EXEC: state_nxt = dp_sts.sample_go ? S_CHK : S_DONE;
      S_CHK:  state_nxt = dp_sts.over_poll ? S_MUL : S_DONE;
      S_MUL:  state_nxt = S_DIV;
      S_DIV:  if (div_cnt_r == '0) state_nxt = S_DEC;
      S_DEC:  state_nxt = S_DONE;
      S_DONE: if (out_free) state_nxt = S_IDLE;
    endcase
  end

  // Outputs to datapath and handshake
  always_comb begin
    ctl_cmd           = '0;
    ctl_cmd.div_shift = div_cnt_r;
    in_ready          = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready        = 1'b1;
        ctl_cmd.load_in = in_valid;
      end
      S_EXEC: ctl_cmd.do_exec  = 1'b1;
      S_CHK:  ctl_cmd.do_chk   = 1'b1;
      S_MUL:  ctl_cmd.do_mul   = 1'b1;
      S_DIV:  ctl_cmd.div_step = 1'b1;
      S_DEC:  ctl_cmd.do_dec   = 1'b1;
      S_DONE: ctl_cmd.load_out = out_free;
    endcase
  end

  // Divider step counter, msb first
  always_comb begin
    div_cnt_nxt = div_cnt_r;
    if (state_r == S_MUL) begin
      div_cnt_nxt = DivTop;
    end else if (state_r == S_DIV && div_cnt_r != '0) begin
      div_cnt_nxt = div_cnt_r - 1'b1;
    end
  end

  // Result register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl_cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hdl/cfgov_datapath.sv =====
// Governor datapath: registers, time totals, active level, load divider
// and the result register. Driven by cfgov_ctrl; depends on cfgov_pkg.
`timescale 1ns / 1ps

module cfgov_datapath #(
  parameter int NUM_LEVELS = 5
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  cfgov_pkg::cmd_t                 ctl_cmd,
  output cfgov_pkg::sts_t                 dp_sts,
  input  logic                            cfg_we,
  input  logic [cfgov_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cfgov_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [cfgov_pkg::CMD_W-1:0]      in_command,
  input  logic [cfgov_pkg::TIME_W-1:0]     in_wall,
  input  logic [cfgov_pkg::TIME_W-1:0]     in_busy,
  input  logic                            in_nap,
  output logic [cfgov_pkg::LVL_W-1:0]      out_level,
  output logic                            out_changed,
  output logic                            out_decided,
  output logic [cfgov_pkg::LOAD_W-1:0]     out_load
);
  import cfgov_pkg::*;

  localparam logic [LVL_W-1:0] MaxLevel = LVL_W'(NUM_LEVELS - 1);

  // Configuration
  logic [POLL_W-1:0] poll_r;
  logic [MODE_W-1:0] mode_r;
  logic [THR_W-1:0]  up_r;
  logic [THR_W-1:0]  down_r;
  logic [LVL_W-1:0]  slow_r;
  logic [LVL_W-1:0]  fast_r;

  // Request and working state
  cmd_code_t         cmd_r;
  logic [TIME_W-1:0] wall_r;
  logic [TIME_W-1:0] busy_r;
  logic              nap_r;
  logic [LVL_W-1:0]  old_lvl_r;
  logic [LVL_W-1:0]  level_r;
  logic [TOT_W-1:0]  wall_tot_r;
  logic [TOT_W-1:0]  busy_tot_r;
  logic [NUM_W-1:0]  num_r;
  logic [TOT_W-1:0]  den_r;
  logic [LOAD_W-1:0] quo_r;
  logic              decided_r;

  logic [POLL_W-1:0]  poll_eff;
  logic [TIME_W-1:0]  busy_clip;
  logic [TOT_W:0]     wall_sum;
  logic [TOT_W:0]     busy_sum;
  logic [NUM_W-1:0]   trial;
  logic [FIELD_W-1:0] up_thr;
  logic [FIELD_W-1:0] down_thr;
  logic [LVL_W-1:0]   dec_level;

  function automatic logic [LVL_W-1:0] cap_lvl(input logic [LVL_W-1:0] v);
    return (v > MaxLevel) ? MaxLevel : v;
  endfunction

  // Clamp up to the fastest limit, then down to the slowest one
  function automatic logic [LVL_W-1:0] clamp_lvl(input logic [LVL_W:0] target);
    logic [LVL_W:0] t;
    logic [LVL_W:0] fast;
    logic [LVL_W:0] slow;
    fast = {1'b0, cap_lvl(fast_r)};
    slow = {1'b0, cap_lvl(slow_r)};
    t    = target;
    if (t < fast) t = fast;
    if (t > slow) t = slow;
    return t[LVL_W-1:0];
  endfunction

  // Register writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_r <= RST_POLL;
      mode_r <= RST_MODE;
      up_r   <= RST_UP;
      down_r <= RST_DOWN;
      slow_r <= RST_SLOW;
      fast_r <= RST_FAST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_POLL: poll_r <= cfg_data[POLL_W-1:0];
        REG_MODE: mode_r <= cfg_data[MODE_W-1:0];
        REG_UP:   up_r   <= cfg_data[THR_W-1:0];
        REG_DOWN: down_r <= cfg_data[THR_W-1:0];
        REG_SLOW: slow_r <= cfg_data[LVL_W-1:0];
        REG_FAST: fast_r <= cfg_data[LVL_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamped poll interval
  always_comb begin
    poll_eff = poll_r;
    if (poll_r < MIN_POLL) poll_eff = MIN_POLL;
    if (poll_r > MAX_POLL) poll_eff = MAX_POLL;
  end

  // Sample accumulation with saturation at the total width
  assign busy_clip = (busy_r > wall_r) ? wall_r : busy_r;
  assign wall_sum  = {1'b0, wall_tot_r} + (TOT_W + 1)'(wall_r);
  assign busy_sum  = {1'b0, busy_tot_r} + (TOT_W + 1)'(busy_clip);

  // Status to controller
  assign dp_sts.sample_go = (cmd_r == CMD_SAMPLE) && (wall_r != '0) && (mode_r == MODE_CONS);
  assign dp_sts.over_poll = wall_tot_r > TOT_W'(poll_eff);

  // Divider trial subtrahend
  assign trial = NUM_W'(den_r) << ctl_cmd.div_shift;

  // Thresholds and stepped level
  always_comb begin
    up_thr   = field7(up_r, level_r);
    down_thr = field7(down_r, level_r);
    if (up_thr > MAX_UP_LOAD) up_thr = MAX_UP_LOAD;
    dec_level = level_r;
    if (quo_r < down_thr) begin
      dec_level = clamp_lvl({1'b0, level_r} + 1'b1);
    end else if (quo_r > up_thr) begin
      dec_level = clamp_lvl((level_r == '0) ? '0 : {1'b0, level_r} - 1'b1);
    end
  end

  // Request latch
  always_ff @(posedge clk) begin
    if (ctl_cmd.load_in) begin
      cmd_r     <= cmd_code_t'(in_command);
      wall_r    <= in_wall;
      busy_r    <= in_busy;
      nap_r     <= in_nap;
      old_lvl_r <= level_r;
    end
  end

  // Totals and active level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wall_tot_r <= '0;
      busy_tot_r <= '0;
      level_r    <= '0;
    end else if (ctl_cmd.do_exec) begin
      unique case (cmd_r)
        CMD_SAMPLE: begin
          if (dp_sts.sample_go) begin
            wall_tot_r <= wall_sum[TOT_W] ? '1 : wall_sum[TOT_W-1:0];
            busy_tot_r <= busy_sum[TOT_W] ? '1 : busy_sum[TOT_W-1:0];
          end
        end
        CMD_WAKE: begin
          if (!nap_r && mode_r == MODE_CONS) begin
            wall_tot_r <= '0;
            busy_tot_r <= '0;
          end
        end
        CMD_SLEEP: begin
          if (mode_r == MODE_CONS || mode_r == MODE_SAVE) begin
            level_r <= clamp_lvl({1'b0, cap_lvl(slow_r)});
          end
        end
        CMD_APPLY: begin
          if (mode_r == MODE_SAVE) begin
            level_r <= clamp_lvl({1'b0, cap_lvl(slow_r)});
          end else if (mode_r != MODE_CONS) begin
            level_r <= clamp_lvl({1'b0, cap_lvl(fast_r)});
          end
        end
      endcase
    end else if (ctl_cmd.do_chk) begin
      if (busy_tot_r > wall_tot_r) busy_tot_r <= wall_tot_r;
    end else if (ctl_cmd.do_dec) begin
      wall_tot_r <= '0;
      busy_tot_r <= '0;
      level_r    <= dec_level;
    end
  end

  // Load divider: 100*busy by shifts, then restoring steps msb first
  always_ff @(posedge clk) begin
    if (ctl_cmd.load_in) begin
      quo_r     <= '0;
      decided_r <= 1'b0;
    end else if (ctl_cmd.do_mul) begin
      num_r <= (NUM_W'(busy_tot_r) << 6) + (NUM_W'(busy_tot_r) << 5)
             + (NUM_W'(busy_tot_r) << 2);
      den_r <= wall_tot_r;
      quo_r <= '0;
    end else if (ctl_cmd.div_step) begin
      if (num_r >= trial) begin
        num_r                     <= num_r - trial;
        quo_r[ctl_cmd.div_shift] <= 1'b1;
      end
    end else if (ctl_cmd.do_dec) begin
      decided_r <= 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (ctl_cmd.load_out) begin
      out_level   <= level_r;
      out_changed <= level_r != old_lvl_r;
      out_decided <= decided_r;
      out_load    <= quo_r;
    end
  end

endmodule

// ===== hdl/conservative_freq_governor_core.sv =====
// Top level of the conservative frequency governor.
// Joins cfgov_ctrl and cfgov_datapath to the channel interfaces of cfgov_ifs; uses cfgov_pkg.
`timescale 1ns / 1ps

// One event request in, one result out. Wake, sleep, mode apply and samples that
// are ignored pass through the exec step only; a sample that only accumulates
// also passes the check step; a sample that crosses the poll interval also runs
// the multiply, the 7-step restoring divider forming load = 100*busy/wall and
// the decide step. The result waits in an output register, so the next event is
// accepted while it is pending; the register write port is always ready, and the
// user must write it only while no event is in flight; nothing in the block enforces this.
module conservative_freq_governor_core #(
  parameter int NUM_LEVELS = 5
) (
  input logic        clk,
  input logic        rst_n,
  cfgov_in_if.sink   in_chan,
  cfgov_out_if.source out_chan,
  cfgov_cfg_if.sink  cfg_chan
);
  import cfgov_pkg::*;

  localparam logic [LVL_W-1:0] MaxLevel = LVL_W'(NUM_LEVELS - 1);

  cmd_t ctl_cmd;
  sts_t dp_sts;

  assign cfg_chan.ready = 1'b1;

  cfgov_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .dp_sts    (dp_sts),
    .ctl_cmd   (ctl_cmd)
  );

  cfgov_datapath #(
    .NUM_LEVELS (NUM_LEVELS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl_cmd     (ctl_cmd),
    .dp_sts      (dp_sts),
    .cfg_we      (cfg_chan.valid && cfg_chan.ready),
    .cfg_index   (cfg_chan.index),
    .cfg_data    (cfg_chan.data),
    .in_command  (in_chan.command),
    .in_wall     (in_chan.wall_time_us),
    .in_busy     (in_chan.busy_time_us),
    .in_nap      (in_chan.was_napping),
    .out_level   (out_chan.power_level),
    .out_changed (out_chan.level_changed),
    .out_decided (out_chan.decision_taken),
    .out_load    (out_chan.load_percent)
  );

  // One request at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> !in_chan.ready)
    else $error("request accepted while previous one still in flight");

  // Multiply always hands over to the divider
  a_mul_then_div: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_cmd.do_mul |=> ctl_cmd.div_step)
    else $error("divider did not start after multiply");

  // Load is saturated and only reported with a decision
  a_load_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.decision_taken ? (out_chan.load_percent <= FULL_LOAD)
                                                : (out_chan.load_percent == '0)))
    else $error("load percent out of range or reported without decision");

  // Level stays inside the level table
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> out_chan.power_level <= MaxLevel)
    else $error("power level beyond last level");

endmodule

// ===== bench/conservative_freq_governor_core_tb.sv =====
// Testbench for conservative_freq_governor_core: directed governor events, then random ones
// under several idling phases, checked against an in-bench prediction of the level logic.
// Depends on cfgov_pkg and the channel interfaces in cfgov_ifs.
`timescale 1ns / 1ps

module conservative_freq_governor_core_tb;
  import cfgov_pkg::*;

  localparam int LEVELS      = 5;
  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 300;
  localparam int END_WAIT    = 40;
  localparam logic [TOT_W-1:0] TOT_MAX = '1;
  // Unlisted mode code, behaves as performance
  localparam logic [MODE_W-1:0] MODE_PERF_ALT = 2'd3;

  // One governor result as seen on the output channel
  typedef struct packed {
    logic [LVL_W-1:0]  level;
    logic              changed;
    logic              decided;
    logic [LOAD_W-1:0] load;
  } gov_result_t;

  // Level governor prediction plus the queue of results still owed by the block
  class governor_scoreboard;
    logic [POLL_W-1:0] poll;
    logic [MODE_W-1:0] mode;
    logic [THR_W-1:0]  up_thr;
    logic [THR_W-1:0]  down_thr;
    logic [LVL_W-1:0]  slow_lvl;
    logic [LVL_W-1:0]  fast_lvl;
    logic [TOT_W-1:0]  wall_tot;
    logic [TOT_W-1:0]  busy_tot;
    logic [LVL_W-1:0]  level;
    gov_result_t       owed_results[$];
    int                errors;
    int                reported;

    function new();
      poll     = RST_POLL;
      mode     = RST_MODE;
      up_thr   = RST_UP;
      down_thr = RST_DOWN;
      slow_lvl = RST_SLOW;
      fast_lvl = RST_FAST;
      wall_tot = '0;
      busy_tot = '0;
      level    = '0;
      errors   = 0;
      reported = 0;
    endfunction

    function int pending();
      return owed_results.size();
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_POLL: poll = data[POLL_W-1:0];
        REG_MODE: mode = data[MODE_W-1:0];
        REG_UP:   up_thr = data[THR_W-1:0];
        REG_DOWN: down_thr = data[THR_W-1:0];
        REG_SLOW: slow_lvl = data[LVL_W-1:0];
        REG_FAST: fast_lvl = data[LVL_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned cap_to_levels(int unsigned v);
      return (v > LEVELS - 1) ? LEVELS - 1 : v;
    endfunction

    // Fastest limit first, then slowest; slowest wins when they cross
    function logic [LVL_W-1:0] clamp_target(int unsigned target);
      int unsigned lo;
      int unsigned hi;
      lo = cap_to_levels(fast_lvl);
      hi = cap_to_levels(slow_lvl);
      if (target < lo) target = lo;
      if (target > hi) target = hi;
      return target[LVL_W-1:0];
    endfunction

    // Levels past the fifth carry no thresholds
    function logic [FIELD_W-1:0] thr_field(logic [THR_W-1:0] thr_word, int unsigned lvl);
      logic [THR_W-1:0] shifted;
      if (lvl >= 5) return '0;
      shifted = thr_word >> (FIELD_W * lvl);
      return shifted[FIELD_W-1:0];
    endfunction

    function logic [TOT_W-1:0] sat_sum(logic [TOT_W-1:0] a, logic [TOT_W-1:0] b);
      logic [TOT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TOT_W] ? TOT_MAX : s[TOT_W-1:0];
    endfunction

    // Advance the governor by one request and queue the result it owes
    function void note_event(cmd_code_t cmd, logic [TIME_W-1:0] wall,
                             logic [TIME_W-1:0] busy, logic nap);
      logic [LVL_W-1:0]   prev;
      gov_result_t        res;
      longint unsigned    lim;
      longint unsigned    load;
      longint unsigned    busy_wide;
      logic [FIELD_W-1:0] up_pct;
      logic [FIELD_W-1:0] down_pct;
      logic [TIME_W-1:0]  busy_c;
      int unsigned        lvl;
      prev = level;
      res  = '0;
      case (cmd)
        CMD_SAMPLE: begin
          if (wall != 0 && mode == MODE_CONS) begin
            lim = poll;
            if (lim < MIN_POLL) lim = MIN_POLL;
            if (lim > MAX_POLL) lim = MAX_POLL;
            busy_c = (busy > wall) ? wall : busy;
            wall_tot = sat_sum(wall_tot, {2'b00, wall});
            busy_tot = sat_sum(busy_tot, {2'b00, busy_c});
            if (busy_tot > wall_tot) busy_tot = wall_tot;
            if (wall_tot > lim) begin
              lvl      = level;
              up_pct   = thr_field(up_thr, lvl);
              down_pct = thr_field(down_thr, lvl);
              if (up_pct > MAX_UP_LOAD) up_pct = MAX_UP_LOAD;
              busy_wide = busy_tot;
              load = (busy_wide * 100) / wall_tot;
              wall_tot = '0;
              busy_tot = '0;
              res.decided = 1'b1;
              res.load = load[LOAD_W-1:0];
              if (load < down_pct) level = clamp_target(lvl + 1);
              else if (load > up_pct) level = clamp_target((lvl == 0) ? 0 : lvl - 1);
            end
          end
        end
        CMD_WAKE: begin
          if (!nap && mode == MODE_CONS) begin
            wall_tot = '0;
            busy_tot = '0;
          end
        end
        CMD_SLEEP: begin
          if (mode < MODE_PERF) level = clamp_target(cap_to_levels(slow_lvl));
        end
        default: begin
          if (mode == MODE_SAVE) level = clamp_target(cap_to_levels(slow_lvl));
          else if (mode >= MODE_PERF) level = clamp_target(cap_to_levels(fast_lvl));
        end
      endcase
      res.level   = level;
      res.changed = (level != prev);
      owed_results.push_back(res);
    endfunction

    function void check_result(gov_result_t act);
      gov_result_t exp;
      if (owed_results.size() == 0) begin
        errors++;
        if (reported < 10) begin
          reported++;
          $display("[%0t] unexpected result: level %0d changed %0b decided %0b load %0d",
                   $realtime, act.level, act.changed, act.decided, act.load);
        end
        return;
      end
      exp = owed_results.pop_front();
      if (act.level !== exp.level || act.changed !== exp.changed ||
          act.decided !== exp.decided || act.load !== exp.load) begin
        errors++;
        if (reported < 10) begin
          reported++;
          $display("[%0t] mismatch (exp/act): level %0d/%0d changed %0b/%0b",
                   $realtime, exp.level, act.level, exp.changed, act.changed);
          $display("    decided %0b/%0b load %0d/%0d",
                   exp.decided, act.decided, exp.load, act.load);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic rx_hold = 1'b0;
  int   in_idle_pct = 0;
  int   out_stall_pct = 0;
  int   cycle_count = 0;
  int unsigned poll_hint = RST_POLL;
  event hold_go;

  governor_scoreboard sb = new();

  cfgov_in_if  in_if ();
  cfgov_out_if out_if ();
  cfgov_cfg_if cfg_if ();

  conservative_freq_governor_core #(.NUM_LEVELS(LEVELS)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  always #2 clk = ~clk;

  // Timeout guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Handshake monitor: register writes, accepted requests, accepted results
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) sb.set_reg(cfg_if.index, cfg_if.data);
      if (in_if.valid && in_if.ready)
        sb.note_event(cmd_code_t'(in_if.command), in_if.wall_time_us,
                      in_if.busy_time_us, in_if.was_napping);
      if (out_if.valid && out_if.ready)
        sb.check_result('{out_if.power_level, out_if.level_changed,
                          out_if.decision_taken, out_if.load_percent});
    end
  end

  // Result receiver with random stalls
  always @(negedge clk) begin
    if (rx_hold) out_if.ready <= 1'b0;
    else out_if.ready <= ($urandom_range(99) >= out_stall_pct);
  end

  // Long receiver hold-off, counted here
  always begin
    @(hold_go);
    @(posedge clk);
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold = 1'b0;
  end

  task automatic send_event(cmd_code_t cmd, logic [TIME_W-1:0] wall,
                            logic [TIME_W-1:0] busy, logic nap);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.command      <= cmd;
    in_if.wall_time_us <= wall;
    in_if.busy_time_us <= busy;
    in_if.was_napping  <= nap;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Stop offering requests and wait for every owed result
  task automatic drain_results();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic configure_random();
    logic [POLL_W-1:0] poll_val;
    logic [MODE_W-1:0] mode_val;
    logic [THR_W-1:0]  up_val;
    logic [THR_W-1:0]  down_val;
    int unsigned       pick;
    pick = $urandom_range(99);
    if (pick < 50) poll_val = POLL_W'($urandom_range(40000, 10000));
    else if (pick < 65) poll_val = MIN_POLL;
    else if (pick < 75) poll_val = MAX_POLL;
    else if (pick < 85) poll_val = '0;
    else if (pick < 95) poll_val = '1;
    else poll_val = POLL_W'($urandom());
    poll_hint = (poll_val < MIN_POLL) ? MIN_POLL : (poll_val > MAX_POLL) ? MAX_POLL : poll_val;
    write_reg(REG_POLL, poll_val);

    if ($urandom_range(99) < 65) mode_val = MODE_CONS;
    else mode_val = MODE_W'($urandom_range(3));
    write_reg(REG_MODE, mode_val);

    // thresholds: mostly sane per-level values, sometimes raw or extreme words
    pick = $urandom_range(99);
    if (pick < 60) begin
      for (int i = 0; i < 5; i++) begin
        up_val[FIELD_W*i +: FIELD_W]   = FIELD_W'($urandom_range(127, 50));
        down_val[FIELD_W*i +: FIELD_W] = FIELD_W'($urandom_range(60, 0));
      end
    end else if (pick < 80) begin
      up_val   = THR_W'({$urandom(), $urandom()});
      down_val = THR_W'({$urandom(), $urandom()});
    end else if (pick < 90) begin
      up_val   = '1;
      down_val = '1;
    end else begin
      up_val   = '0;
      down_val = '0;
    end
    write_reg(REG_UP, up_val);
    write_reg(REG_DOWN, down_val);

    if ($urandom_range(99) < 60) begin
      write_reg(REG_SLOW, 3'd4);
      write_reg(REG_FAST, 3'd0);
    end else begin
      write_reg(REG_SLOW, CFG_DATA_W'($urandom_range(7)));
      write_reg(REG_FAST, CFG_DATA_W'($urandom_range(7)));
    end
  endtask

  task automatic random_item();
    int unsigned       pick;
    logic [TIME_W-1:0] wall;
    logic [TIME_W-1:0] busy;
    cmd_code_t         cmd;
    pick = $urandom_range(99);
    if (pick < 70) cmd = CMD_SAMPLE;
    else if (pick < 80) cmd = CMD_WAKE;
    else if (pick < 90) cmd = CMD_SLEEP;
    else cmd = CMD_APPLY;
    // wall mostly a fraction of the poll interval so decisions come often
    pick = $urandom_range(99);
    if (pick < 5) wall = '0;
    else if (pick < 12) wall = $urandom();
    else wall = $urandom_range(poll_hint / 2, poll_hint / 8 + 1);
    if ($urandom_range(99) < 10) busy = $urandom();
    else busy = $urandom_range(wall, 0);
    send_event(cmd, wall, busy, 1'($urandom_range(1)));
  endtask

  initial begin
    rst_n               = 1'b0;
    in_if.valid         = 1'b0;
    in_if.command       = CMD_SAMPLE;
    in_if.wall_time_us  = '0;
    in_if.busy_time_us  = '0;
    in_if.was_napping   = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = REG_POLL;
    cfg_if.data         = '0;
    out_if.ready        = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings are performance mode: samples ignored, sleep keeps level
    send_event(CMD_SAMPLE, 32'd20000, 32'd20000, 1'b0);
    send_event(CMD_SLEEP, '0, '0, 1'b0);
    send_event(CMD_APPLY, '0, '0, 1'b0);
    send_event(CMD_WAKE, '1, '1, 1'b1);
    drain_results();

    // Energy save: sleep and apply go to the slowest level
    write_reg(REG_MODE, MODE_SAVE);
    send_event(CMD_SLEEP, '0, '0, 1'b0);
    send_event(CMD_APPLY, '0, '0, 1'b0);
    send_event(CMD_SAMPLE, 32'd50000, 32'd50000, 1'b0);
    drain_results();

    // Conservative, poll below range (reads as the minimum)
    write_reg(REG_MODE, MODE_CONS);
    write_reg(REG_POLL, '0);
    send_event(CMD_SAMPLE, '0, '1, 1'b0);                   // zero wall ignored
    send_event(CMD_SAMPLE, 32'd5000, 32'd2500, 1'b0);
    send_event(CMD_SAMPLE, 32'd5000, 32'd2500, 1'b0);       // equal to poll, no decision
    send_event(CMD_SAMPLE, 32'd1, 32'd1, 1'b0);             // crosses poll
    send_event(CMD_SAMPLE, '1, '1, 1'b0);                   // full load, step faster
    send_event(CMD_SAMPLE, 32'd20000, 32'd50000, 1'b0);     // busy above wall
    send_event(CMD_SAMPLE, 32'd20000, '0, 1'b0);            // idle, step slower
    send_event(CMD_SAMPLE, 32'd6000, 32'd6000, 1'b0);
    send_event(CMD_WAKE, '0, '0, 1'b0);                     // clears totals
    send_event(CMD_SAMPLE, 32'd6000, '0, 1'b0);
    send_event(CMD_WAKE, '0, '0, 1'b1);                     // from nap: totals kept
    send_event(CMD_SAMPLE, 32'd6000, '0, 1'b0);
    send_event(CMD_SLEEP, '0, '0, 1'b0);
    send_event(CMD_APPLY, '0, '0, 1'b0);
    drain_results();

    // Poll above range, up thresholds over the cap, crossed level limits
    write_reg(REG_POLL, '1);
    write_reg(REG_UP, '1);
    write_reg(REG_DOWN, '0);
    write_reg(REG_SLOW, 3'd7);
    write_reg(REG_FAST, 3'd6);
    send_event(CMD_SAMPLE, '1, '0, 1'b0);
    drain_results();
    write_reg(REG_MODE, MODE_PERF_ALT);                     // acts as performance
    send_event(CMD_APPLY, '0, '0, 1'b0);
    send_event(CMD_SLEEP, '0, '0, 1'b0);
    drain_results();

    write_reg(REG_FAST, 3'd0);
    write_reg(REG_SLOW, 3'd4);
    write_reg(REG_UP, '0);
    write_reg(REG_DOWN, '1);
    write_reg(REG_MODE, MODE_CONS);
    send_event(CMD_SAMPLE, '1, 32'h7FFF_FFFF, 1'b0);
    send_event(CMD_SAMPLE, '1, 32'h8000_0000, 1'b0);

    // Random phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      for (int seg = 0; seg < 8; seg++) begin
        drain_results();
        configure_random();
        case (ph)
          0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
          1: begin in_idle_pct = 59; out_stall_pct = 0;  end
          2: begin in_idle_pct = 0;  out_stall_pct = 59; end
          default: begin in_idle_pct = 28; out_stall_pct = 28; end
        endcase
        // Receiver holds off while requests keep coming
        if (ph == 0 && seg == 1) -> hold_go;
        repeat ($urandom_range(50, 30)) random_item();
      end
    end

    drain_results();
    repeat (END_WAIT) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
